// File: src/tcw_pkg.sv
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [3:0]  FG_RESET     = 4'hF;
  localparam logic [3:0]  BG_RESET     = 4'h1;
  localparam logic [15:0] RESET_BLANK  = {BG_RESET, FG_RESET, SPACE_CODE};

  // register select, taken from paddr[2]
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef struct packed {
    logic latch;       // take a new command
    logic exec;        // immediate effect of the held command
    logic fill;        // sweep: write blank at sweep counter
    logic init_blank;  // sweep uses the reset blank
    logic scroll;      // sweep: move rows up one
    logic emit;        // load result registers
  } tcw_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    need_scroll;
    logic    fill_last;
    logic    scroll_last;
  } tcw_stat_t;

endpackage

`default_nettype wire

// File: src/text_console_writer_unit.sv
// Top level of the text console writer: configuration registers and submodules.
`timescale 1ns / 1ps
`default_nettype none

// Text console writer. A command is taken when start is high and busy is low;
// its single result appears on the out_ ports for one cycle, flagged by
// out_strobe, and must be captured then, as the receiver has no way to stall.
// Write-character, move and read-cell commands pass through an execute state
// and a done state: busy drops again in the cycle the result register is loaded,
// so the next command can be taken then. A clear walks the whole screen memory
// one cell a cycle; a write that scrolls copies every cell up one row and blanks
// the last row through the single write port of the screen memory. After reset,
// busy stays high while the screen is blanked with the reset attribute 0x1F;
// configuration transfers are still taken then.
// fg_color sits at byte address 0 and bg_color at byte address 4.
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [6:0]  in_col,
  input  wire logic [4:0]  in_row,
  // result channel
  output logic             out_strobe,
  output logic [10:0]      out_cursor_location,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_attr,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tcw_pkg::*;

  logic [3:0] fg_r, bg_r;
  logic       cfg_wr;
  tcw_cmd_t   cmd;
  tcw_stat_t  stat;

  // Configuration: zero wait states, word select on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FG:  fg_r <= pwdata[3:0];
        REG_BG:  bg_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FG:  prdata = {28'd0, fg_r};
      REG_BG:  prdata = {28'd0, bg_r};
      default: prdata = '0;
    endcase
  end

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // attribute byte: background in the high nibble, foreground in the low
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_opcode           (in_opcode),
    .in_char_code        (in_char_code),
    .in_col              (in_col),
    .in_row              (in_row),
    .attr                ({bg_r, fg_r}),
    .cmd                 (cmd),
    .stat                (stat),
    .out_strobe          (out_strobe),
    .out_cursor_location (out_cursor_location),
    .out_cell_char       (out_cell_char),
    .out_cell_attr       (out_cell_attr)
  );

  // each command yields a single one-cycle result
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // the blanking pass keeps commands out straight after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("command port open during the reset blanking pass");

endmodule

`default_nettype wire

// File: src/tcw_ctrl.sv
// Controller state machine for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire tcw_pkg::tcw_stat_t stat,
  output tcw_pkg::tcw_cmd_t     cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign busy = !(state_r == ST_IDLE || state_r == ST_DONE);
  assign take = start && !busy;

  always_comb begin
    cmd            = '0;
    cmd.latch      = take;
    cmd.exec       = (state_r == ST_EXEC);
    cmd.fill       = (state_r == ST_INIT) || (state_r == ST_FILL);
    cmd.init_blank = (state_r == ST_INIT);
    cmd.scroll     = (state_r == ST_SCROLL);
    cmd.emit       = (state_r == ST_DONE);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:   if (stat.fill_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (take) state_nxt = ST_EXEC;
      ST_EXEC: begin
        unique case (stat.op)
          OP_WRITE: state_nxt = stat.need_scroll ? ST_SCROLL : ST_DONE;
          OP_CLEAR: state_nxt = ST_FILL;
          OP_MOVE:  state_nxt = ST_DONE;
          OP_READ:  state_nxt = ST_DONE;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_FILL:   if (stat.fill_last) state_nxt = ST_DONE;
      ST_SCROLL: if (stat.scroll_last) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = take ? ST_EXEC : ST_IDLE;
      default:   state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a result only follows real work
  a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> ($past(state_r) == ST_EXEC || $past(state_r) == ST_FILL ||
                            $past(state_r) == ST_SCROLL))
    else $error("done state entered without work");

endmodule

`default_nettype wire

// File: src/tcw_datapath.sv
// Datapath for the text console writer: screen memory, cursor and sweep counter.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    in_opcode,
  input  wire logic [7:0]    in_char_code,
  input  wire logic [6:0]    in_col,
  input  wire logic [4:0]    in_row,
  input  wire logic [7:0]    attr,
  input  wire tcw_pkg::tcw_cmd_t cmd,
  output tcw_pkg::tcw_stat_t stat,
  output logic               out_strobe,
  output logic [10:0]        out_cursor_location,
  output logic [7:0]         out_cell_char,
  output logic [7:0]         out_cell_attr
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int SW     = $clog2(CELLS + 1);
  localparam int LOC_W  = (AW > 11) ? AW : 11;
  localparam int COPY_N = CELLS - COLUMNS;

  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [SW-1:0] COPY_S    = SW'(COPY_N);
  localparam logic [SW-1:0] FILL_LAST = SW'(CELLS - 1);
  localparam logic [SW-1:0] SCR_LAST  = SW'(CELLS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;

  opcode_t       op_r;
  logic [7:0]    char_r;
  logic [CW-1:0] mcol_r, mcol_nxt;
  logic [RW-1:0] mrow_r, mrow_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [SW-1:0] cnt_r, cnt_m1;

  logic          out_strobe_r;
  logic [10:0]   out_loc_r;
  logic [7:0]    out_char_r, out_attr_r;

  logic          is_nl, adv_row, at_last_row;
  logic [AW-1:0] cur_idx, rd_idx;
  logic [LOC_W-1:0] loc_full;
  logic [15:0]   blank;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;

  // clamp move/read coordinates as they arrive
  always_comb begin
    mcol_nxt = (int'(in_col) >= COLUMNS) ? LAST_COL : CW'(in_col);
    mrow_nxt = (int'(in_row) >= ROWS) ? LAST_ROW : RW'(in_row);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= opcode_t'(in_opcode);
      char_r <= in_char_code;
      mcol_r <= mcol_nxt;
      mrow_r <= mrow_nxt;
    end
  end

  assign is_nl       = (char_r == NEWLINE_CODE);
  assign adv_row     = is_nl || (cur_col_r == LAST_COL);
  assign at_last_row = (cur_row_r == LAST_ROW);
  assign cur_idx     = AW'(cur_col_r) + AW'(cur_row_r) * COLS_A;
  assign rd_idx      = AW'(mcol_r) + AW'(mrow_r) * COLS_A;
  assign loc_full    = LOC_W'(cur_idx);
  assign blank       = {attr, SPACE_CODE};
  assign cnt_m1      = cnt_r - 1'b1;

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (cmd.exec) begin
      unique case (op_r)
        OP_WRITE: begin
          cur_col_nxt = adv_row ? '0 : CW'(cur_col_r + 1'b1);
          if (adv_row && !at_last_row) cur_row_nxt = RW'(cur_row_r + 1'b1);
        end
        OP_MOVE: begin
          cur_col_nxt = mcol_r;
          cur_row_nxt = mrow_r;
        end
        OP_CLEAR: begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
        end
        OP_READ: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      cnt_r     <= '0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      if (cmd.exec) begin
        cnt_r <= '0;
      end else if (cmd.fill || cmd.scroll) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // memory port selection; the scroll copy reads one row ahead of its write
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = blank;
    priority if (cmd.fill) begin
      we    = 1'b1;
      waddr = cnt_r[AW-1:0];
      wdata = cmd.init_blank ? RESET_BLANK : blank;
    end else if (cmd.exec) begin
      if (op_r == OP_WRITE && !is_nl) begin
        we    = 1'b1;
        waddr = cur_idx;
        wdata = {attr, char_r};
      end
      if (op_r == OP_READ) begin
        re    = 1'b1;
        raddr = rd_idx;
      end
    end else if (cmd.scroll) begin
      if (cnt_r < COPY_S) begin
        re    = 1'b1;
        raddr = cnt_r[AW-1:0] + COLS_A;
      end
      if (cnt_r != '0) begin
        we    = 1'b1;
        waddr = cnt_m1[AW-1:0];
        wdata = (cnt_r <= COPY_S) ? rdata_r : blank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  always_comb begin
    stat             = '0;
    stat.op          = op_r;
    stat.need_scroll = (op_r == OP_WRITE) && adv_row && at_last_row;
    stat.fill_last   = (cnt_r == FILL_LAST);
    stat.scroll_last = (cnt_r == SCR_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_loc_r  <= loc_full[10:0];
      out_char_r <= (op_r == OP_READ) ? rdata_r[7:0] : '0;
      out_attr_r <= (op_r == OP_READ) ? rdata_r[15:8] : '0;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_cursor_location = out_loc_r;
  assign out_cell_char       = out_char_r;
  assign out_cell_attr       = out_attr_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr))
    else $error("screen memory read and write hit the same cell");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (int'(cur_col_r) < COLUMNS && int'(cur_row_r) < ROWS))
    else $error("cursor left the screen");

endmodule

`default_nettype wire

// File: test/text_console_writer_unit_tb.sv
// Self-checking testbench for the text console writer: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

import tcw_pkg::*;

// Mirrors the screen memory, cursor and colour registers and holds the reports still due.
class console_scoreboard #(int COLS = 80, int LINES = 25);
  localparam int CELLS = COLS * LINES;

  typedef struct packed {
    logic [10:0] location;
    logic [7:0]  char_code;
    logic [7:0]  attr;
  } cursor_report_t;

  logic [15:0]    screen [CELLS];
  int unsigned    cur_col, cur_row;
  logic [3:0]     fg, bg;
  cursor_report_t cursor_reports[$];
  int unsigned    errors, writes, scrolls, clears, reads, moves;

  function new();
    for (int i = 0; i < CELLS; i++) screen[i] = RESET_BLANK;
    cur_col = 0;
    cur_row = 0;
    fg = FG_RESET;
    bg = BG_RESET;
  endfunction

  function void set_colour(logic is_bg, logic [3:0] value);
    if (is_bg == REG_BG) bg = value;
    else fg = value;
  endfunction

  function logic [15:0] blank_cell();
    return {bg, fg, SPACE_CODE};
  endfunction

  function void put_char(logic [7:0] ch);
    if (ch == NEWLINE_CODE) begin
      cur_row++;
      cur_col = 0;
    end else begin
      screen[cur_col + cur_row * COLS] = {bg, fg, ch};
      cur_col++;
    end
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= LINES) begin
      cur_row = LINES - 1;
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = blank_cell();
      scrolls++;
    end
  endfunction

  // Works out the report for one accepted command and queues it.
  function void apply_command(opcode_t op, logic [7:0] ch, logic [6:0] col, logic [4:0] row);
    cursor_report_t rep;
    int unsigned    c, r;
    rep = '0;
    c = (col >= COLS) ? COLS - 1 : col;
    r = (row >= LINES) ? LINES - 1 : row;
    case (op)
      OP_WRITE: begin
        put_char(ch);
        writes++;
      end
      OP_MOVE: begin
        cur_col = c;
        cur_row = r;
        moves++;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
        clears++;
      end
      default: begin
        rep.char_code = screen[c + r * COLS][7:0];
        rep.attr      = screen[c + r * COLS][15:8];
        reads++;
      end
    endcase
    rep.location = 11'(cur_col + cur_row * COLS);
    cursor_reports.push_back(rep);
  endfunction

  function void check_report(logic [10:0] location, logic [7:0] ch, logic [7:0] attr);
    cursor_report_t want;
    if (cursor_reports.size() == 0) begin
      $error("result transfer with no command outstanding: location %0d", location);
      errors++;
      return;
    end
    want = cursor_reports.pop_front();
    if (location !== want.location) begin
      $error("cursor_location: expected %0d, got %0d", want.location, location);
      errors++;
    end
    if (ch !== want.char_code) begin
      $error("cell_char: expected 0x%02h, got 0x%02h", want.char_code, ch);
      errors++;
    end
    if (attr !== want.attr) begin
      $error("cell_attr: expected 0x%02h, got 0x%02h", want.attr, attr);
      errors++;
    end
  endfunction
endclass

module text_console_writer_unit_tb;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  // A clear or a scrolling write holds busy while it sweeps the screen memory, as does
  // the blanking pass after reset; the limit leaves ample margin over both.
  localparam int STALL_LIMIT  = 12000;
  localparam int PHASE_ITEMS  = 172;
  localparam int SETTLE_TICKS = 8;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [7:0]  in_char_code;
  logic [6:0]  in_col;
  logic [4:0]  in_row;
  logic        out_strobe;
  logic [10:0] out_cursor_location;
  logic [7:0]  out_cell_char;
  logic [7:0]  out_cell_attr;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  console_scoreboard #(COLUMNS, ROWS) sb;
  int unsigned cmds_taken;
  int unsigned quiet_cycles;

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_char_code       (in_char_code),
    .in_col             (in_col),
    .in_row             (in_row),
    .out_strobe         (out_strobe),
    .out_cursor_location(out_cursor_location),
    .out_cell_char      (out_cell_char),
    .out_cell_attr      (out_cell_attr),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitor: everything is sampled on the rising edge. A result can never belong to a
  // command taken at the same edge, so checking before noting is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1)
        sb.check_report(out_cursor_location, out_cell_char, out_cell_attr);
      if (start && !busy) begin
        sb.apply_command(opcode_t'(in_opcode), in_char_code, in_col, in_row);
        cmds_taken++;
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1 || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("text_console_writer_unit verification failed");
      $finish;
    end
  end

  // All driving tasks are entered and left on a falling edge.
  task automatic send_command(opcode_t op, logic [7:0] ch, logic [6:0] col, logic [4:0] row);
    int unsigned seen;
    seen = cmds_taken;
    start        = 1'b1;
    in_opcode    = op;
    in_char_code = ch;
    in_col       = col;
    in_row       = row;
    do @(negedge clk); while (cmds_taken == seen);
  endtask

  // Sender gap, taken in pct percent of calls, so stalls land on every stage of a command.
  task automatic maybe_idle(int pct);
    if ($urandom_range(99) < pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Block is idle once every report is in and busy has dropped.
  task automatic drain();
    start = 1'b0;
    while (sb.cursor_reports.size() != 0 || busy) @(negedge clk);
  endtask

  // APB write: setup then access; junk in the upper bits must be ignored.
  // The register is then read back over the same port.
  task automatic write_colour(logic is_bg, logic [3:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {is_bg, 2'b00};
    pwdata  = {28'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (!pready);
    penable = 1'b0;
    pwrite  = 1'b0;
    sb.set_colour(is_bg, value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== {28'd0, value}) begin
      $error("prdata: expected 0x%08h, got 0x%08h", {28'd0, value}, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_colours(logic [3:0] fg_val, logic [3:0] bg_val);
    drain();
    write_colour(REG_FG, fg_val);
    write_colour(REG_BG, bg_val);
  endtask

  // Random command mix: mostly text, with bursts, plus moves (often clamped to the
  // bottom row, which makes scrolls frequent), rare clears and reads near the cursor.
  task automatic random_command();
    int         pick;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] row;
    pick = $urandom_range(99);
    col  = 7'($urandom);
    row  = 5'($urandom);
    ch   = ($urandom_range(9) == 0) ? NEWLINE_CODE : 8'($urandom);
    if (pick < 50) begin
      send_command(OP_WRITE, ch, col, row);
    end else if (pick < 56) begin
      // burst of text
      repeat ($urandom_range(5, 30)) begin
        ch = ($urandom_range(11) == 0) ? NEWLINE_CODE : 8'($urandom_range(32, 126));
        send_command(OP_WRITE, ch, 7'($urandom), 5'($urandom));
      end
    end else if (pick < 72) begin
      send_command(OP_MOVE, ch, col, row);
    end else if (pick < 75) begin
      send_command(OP_CLEAR, ch, col, row);
    end else begin
      if ($urandom_range(1)) begin
        // likely to land on freshly written cells
        row = 5'(sb.cur_row);
        col = 7'($urandom_range(COLUMNS - 1));
      end
      send_command(OP_READ, ch, col, row);
    end
  endtask

  task automatic random_phase(int idle_pct);
    repeat (PHASE_ITEMS) begin
      random_command();
      maybe_idle(idle_pct);
    end
  endtask

  initial begin
    sb           = new();
    cmds_taken   = 0;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_opcode    = OP_WRITE;
    in_char_code = '0;
    in_col       = '0;
    in_row       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // screen blanking pass after reset
    do @(negedge clk); while (busy);

    // Directed: reset contents, clamping, field extremes, wrap, scroll, clear.
    send_command(OP_READ,  8'hFF, 7'd0,   5'd0);   // reset blank with reset attribute
    send_command(OP_READ,  8'h00, 7'd127, 5'd31);  // clamped to the last cell
    send_command(OP_WRITE, 8'h41, 7'd127, 5'd31);
    send_command(OP_WRITE, 8'h00, 7'd0,   5'd0);
    send_command(OP_WRITE, 8'hFF, 7'd0,   5'd0);
    send_command(OP_WRITE, NEWLINE_CODE, 7'd0, 5'd0);
    send_command(OP_READ,  8'h00, 7'd2,   5'd0);
    send_command(OP_MOVE,  8'hFF, 7'd79,  5'd0);
    send_command(OP_WRITE, 8'h5A, 7'd0,   5'd0);   // last column, wraps to next row
    send_command(OP_MOVE,  8'h00, 7'd127, 5'd31);  // clamps to bottom-right
    send_command(OP_WRITE, 8'h7E, 7'd0,   5'd0);   // wrap off the bottom: scroll
    send_command(OP_READ,  8'h00, 7'd79,  5'd23);
    send_command(OP_READ,  8'h00, 7'd0,   5'd24);
    send_command(OP_MOVE,  8'h00, 7'd80,  5'd24);
    send_command(OP_WRITE, NEWLINE_CODE, 7'd5, 5'd5);  // newline on bottom row: scroll
    send_command(OP_READ,  8'h00, 7'd79,  5'd22);
    send_command(OP_CLEAR, 8'hFF, 7'd127, 5'd31);
    send_command(OP_READ,  8'h00, 7'd5,   5'd5);
    set_colours(4'h0, 4'h0);
    send_command(OP_WRITE, 8'h80, 7'd0,   5'd0);
    send_command(OP_READ,  8'h00, 7'd0,   5'd0);
    set_colours(4'hF, 4'hF);
    send_command(OP_CLEAR, 8'h00, 7'd0,   5'd0);
    send_command(OP_READ,  8'h00, 7'd64,  5'd16);
    send_command(OP_WRITE, 8'h7F, 7'd0,   5'd0);
    send_command(OP_READ,  8'h00, 7'd0,   5'd0);

    // Random: sender idles rarely, then often, then not at all.
    set_colours(4'($urandom), 4'($urandom));
    random_phase(13);
    set_colours(4'($urandom), 4'($urandom));
    random_phase(45);
    set_colours(FG_RESET, 4'h0);
    random_phase(0);

    drain();
    repeat (SETTLE_TICKS) @(negedge clk);

    $display("Ran %0d commands over six colour settings: %0d writes, %0d moves, %0d reads,",
             cmds_taken, sb.writes, sb.moves, sb.reads);
    $display("%0d clears and %0d scrolls, with sender gaps in two of three random phases.",
             sb.clears, sb.scrolls);
    if (sb.errors == 0 && sb.cursor_reports.size() == 0) begin
      $display("text_console_writer_unit verification clean");
    end else begin
      $display("text_console_writer_unit verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_writer_unit.sv
test/text_console_writer_unit_tb.sv
